// File: sv/dstof_pkg.sv
// shared types and constants for the two-way ranging time-of-flight block
package dstof_pkg;

  localparam int DEN_W = 34;
  localparam int Q_W   = 32;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [23:0] SCALE_RESET = 24'd307387;

  // one divider word travelling down the cell chain
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   lo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
    logic             ovf;
  } div_t;

  typedef struct packed {
    logic [31:0] flight;
    logic [31:0] distance;
    logic [1:0]  status;
  } res_t;

endpackage

// File: sv/ds_twr_time_of_flight.sv
// top level: double-sided two-way ranging time of flight and distance
// One ranging record is taken per clock and one result leaves per clock
// while the output is not stalled; the pipeline has four setup stages
// (intervals, two 32x32 products, difference, range check), a chain of 32
// division cells giving one quotient bit each, three stages for clamping and
// the 32x24 distance scaling, and the output register. A one-word skid stage
// behind the output register catches the word leaving the chain when the
// output stalls; input and chain freeze while it is full. The scale register
// port is always ready; write it only while no word is in flight.
module ds_twr_time_of_flight #(
  parameter int FRAC_BITS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // poll_sent_time, response_got_time, final_sent_time,
  // poll_got_time, response_sent_time, final_got_time
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // flight_ticks_q4, distance_mm
  output logic [63:0]  m_tdata,
  // status
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data
);

  localparam int NCELL = 32;
  localparam int NST   = 4 + NCELL + 3;

  logic [23:0] scale;
  logic [NST-1:0] vld;
  logic en;
  logic skid_valid;
  dstof_pkg::res_t pipe_res, skid_res, out_res;
  dstof_pkg::div_t chain [0:NCELL];

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= dstof_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  dstof_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .en(en), .stamps(s_tdata), .dout(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    dstof_cell u_cell (.clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1]));
  end

  dstof_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .en(en), .din(chain[NCELL]), .scale(scale), .dout(pipe_res)
  );

  // output register with a skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res  <= pipe_res;
        m_tvalid <= vld[NST-1];
      end
    end else if (vld[NST-1] && !skid_valid) begin
      // chain is frozen while the skid word is full
      skid_res   <= pipe_res;
      skid_valid <= 1'b1;
    end
  end

  assign m_tdata = {out_res.distance, out_res.flight};
  assign m_tuser = out_res.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid word without output word");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !s_tready) else $error("input accepted while skid full");

  a_zero_results: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dstof_pkg::ST_ZERO) |-> (m_tdata == 64'd0))
    else $error("divisor zero with nonzero results");

  a_sign_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dstof_pkg::ST_OK && !m_tdata[31]) |-> !m_tdata[63])
    else $error("distance sign differs from flight sign");

endmodule

// File: sv/dstof_front.sv
// intervals, cross products, difference and divider setup
module dstof_front #(
  parameter int FRAC_BITS = 4
) (
  input  logic                clk,
  input  logic                en,
  input  logic [191:0]        stamps,
  output dstof_pkg::div_t     dout
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int HW = 32 + FRAC_BITS;
  localparam int CW = (HW > dstof_pkg::DEN_W) ? HW : dstof_pkg::DEN_W;

  logic [31:0] ra, rb, da, db;
  logic [63:0] p1, p2;
  logic [dstof_pkg::DEN_W-1:0] den1, den2;
  logic [63:0] mag;
  logic        neg;

  logic [NW-1:0] num;
  logic [HW-1:0] hi;

  always_ff @(posedge clk) begin
    if (en) begin
      ra <= stamps[63:32] - stamps[31:0];
      rb <= stamps[191:160] - stamps[159:128];
      da <= stamps[95:64] - stamps[63:32];
      db <= stamps[159:128] - stamps[127:96];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= ra * rb;
      p2   <= da * db;
      den1 <= dstof_pkg::DEN_W'(ra) + dstof_pkg::DEN_W'(rb)
            + dstof_pkg::DEN_W'(da) + dstof_pkg::DEN_W'(db);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg  <= p2 > p1;
      mag  <= (p2 > p1) ? (p2 - p1) : (p1 - p2);
      den2 <= den1;
    end
  end

  assign num = NW'(mag) << FRAC_BITS;
  assign hi  = num[NW-1:32];

  // quotient of 2^32 or more is out of range for any sign
  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= dstof_pkg::DEN_W'(hi);
      dout.lo   <= num[31:0];
      dout.den  <= den2;
      dout.neg  <= neg;
      dout.zero <= (den2 == '0);
      dout.ovf  <= CW'(hi) >= CW'(den2);
    end
  end

endmodule

// File: sv/dstof_cell.sv
// one restoring division step, one quotient bit per cell
module dstof_cell (
  input  logic            clk,
  input  logic            en,
  input  dstof_pkg::div_t din,
  output dstof_pkg::div_t dout
);

  logic [dstof_pkg::DEN_W:0] shifted;
  logic [dstof_pkg::DEN_W:0] trial;
  logic                      take;

  assign shifted = {din.rem, din.lo[dstof_pkg::Q_W-1]};
  assign trial   = shifted - {1'b0, din.den};
  assign take    = shifted >= {1'b0, din.den};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= take ? trial[dstof_pkg::DEN_W-1:0] : shifted[dstof_pkg::DEN_W-1:0];
      dout.lo   <= {din.lo[dstof_pkg::Q_W-2:0], take};
      dout.den  <= din.den;
      dout.neg  <= din.neg;
      dout.zero <= din.zero;
      dout.ovf  <= din.ovf;
    end
  end

endmodule

// File: sv/dstof_back.sv
// quotient clamp, distance scaling and result formatting
module dstof_back #(
  parameter int FRAC_BITS = 4
) (
  input  logic            clk,
  input  logic            en,
  input  dstof_pkg::div_t din,
  input  logic [23:0]     scale,
  output dstof_pkg::res_t dout
);

  localparam int SH = FRAC_BITS + 16;

  logic [31:0] lim;
  logic [31:0] tq1, tq2;
  logic        neg1, sat1, zero1, neg2, sat2, zero2;
  logic [55:0] prod;
  logic [55:0] dmag;
  logic        dsat;
  logic [31:0] dclamp;

  assign lim = din.neg ? dstof_pkg::NEG_LIMIT : dstof_pkg::POS_LIMIT;

  always_ff @(posedge clk) begin
    if (en) begin
      tq1   <= (din.ovf || din.lo > lim) ? lim : din.lo;
      sat1  <= din.ovf || din.lo > lim;
      neg1  <= din.neg;
      zero1 <= din.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= 56'(tq1) * 56'(scale);
      tq2   <= tq1;
      sat2  <= sat1;
      neg2  <= neg1;
      zero2 <= zero1;
    end
  end

  assign dmag   = prod >> SH;
  assign dsat   = dmag > 56'(neg2 ? dstof_pkg::NEG_LIMIT : dstof_pkg::POS_LIMIT);
  assign dclamp = dsat ? (neg2 ? dstof_pkg::NEG_LIMIT : dstof_pkg::POS_LIMIT) : dmag[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero2) begin
        dout.flight   <= '0;
        dout.distance <= '0;
        dout.status   <= dstof_pkg::ST_ZERO;
      end else begin
        dout.flight   <= neg2 ? (32'd0 - tq2) : tq2;
        dout.distance <= neg2 ? (32'd0 - dclamp) : dclamp;
        dout.status   <= (sat2 || dsat) ? dstof_pkg::ST_SAT : dstof_pkg::ST_OK;
      end
    end
  end

endmodule

// File: tb/tb_ds_twr_time_of_flight.sv
// testbench for the two-way ranging time-of-flight block: directed and random records
`timescale 1ns / 1ps

class flight_scoreboard;
  logic [31:0] flight_q[$];
  logic [31:0] dist_q[$];
  logic [1:0]  status_q[$];
  logic [23:0] scale;
  int          errors;

  function new();
    scale  = dstof_pkg::SCALE_RESET;
    errors = 0;
  endfunction

  function automatic logic [31:0] clamp_bits(logic [63:0] mag, bit neg, ref bit sat);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      sat = 1;
    end
    return neg ? (32'd0 - mag[31:0]) : mag[31:0];
  endfunction

  // work out flight time and distance for one record
  function void note_record(logic [191:0] d);
    logic [31:0]  ra, rb, da, db;
    logic [63:0]  den, p1, p2, mag, lim, q, r, tq, dmag;
    logic [127:0] prod;
    logic [31:0]  fb, db_bits;
    bit           neg, sat;
    ra = d[63:32] - d[31:0];
    rb = d[191:160] - d[159:128];
    da = d[95:64] - d[63:32];
    db = d[159:128] - d[127:96];
    den = 64'(ra) + 64'(rb) + 64'(da) + 64'(db);
    if (den == 0) begin
      flight_q.push_back(0);
      dist_q.push_back(0);
      status_q.push_back(dstof_pkg::ST_ZERO);
      return;
    end
    p1 = 64'(ra) * 64'(rb);
    p2 = 64'(da) * 64'(db);
    neg = p2 > p1;
    mag = neg ? p2 - p1 : p1 - p2;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q = mag / den;
    r = mag % den;
    sat = 0;
    if (q > (lim >> 4)) begin
      tq = lim;
      sat = 1;
    end else begin
      tq = (q << 4) + ((r << 4) / den);
      if (tq > lim) begin
        tq = lim;
        sat = 1;
      end
    end
    fb = clamp_bits(tq, neg, sat);
    prod = 128'(tq) * 128'(scale);
    dmag = prod[83:20];
    db_bits = clamp_bits(dmag, neg, sat);
    flight_q.push_back(fb);
    dist_q.push_back(db_bits);
    status_q.push_back(sat ? dstof_pkg::ST_SAT : dstof_pkg::ST_OK);
  endfunction

  function void check_result(logic [63:0] d, logic [1:0] st);
    logic [31:0] ef, ed;
    logic [1:0]  es;
    if (flight_q.size() == 0) begin
      $display("%0t: unexpected word flight=%h dist=%h status=%0d", $time, d[31:0],
               d[63:32], st);
      errors++;
      return;
    end
    ef = flight_q.pop_front();
    ed = dist_q.pop_front();
    es = status_q.pop_front();
    if (d[31:0] !== ef) begin
      $display("%0t: flight expected %h actual %h", $time, ef, d[31:0]);
      errors++;
    end
    if (d[63:32] !== ed) begin
      $display("%0t: distance expected %h actual %h", $time, ed, d[63:32]);
      errors++;
    end
    if (st !== es) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st);
      errors++;
    end
  endfunction
endclass

module tb_ds_twr_time_of_flight;
  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;

  flight_scoreboard sb;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  longint cycles = 0;

  ds_twr_time_of_flight uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL ds_twr_time_of_flight");
      $finish;
    end
  end

  // receiver side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_record(logic [191:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_record(d);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.flight_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_scale(logic [23:0] v);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.scale = v;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // build a record from the four intervals plus random base times
  function automatic logic [191:0] from_intervals(logic [31:0] ra, rb, da, db);
    logic [31:0] pa, pt;
    pa = $urandom;
    pt = $urandom;
    return {pt + db + rb, pt + db, pt, pa + ra + da, pa + ra, pa};
  endfunction

  function automatic logic [31:0] rnd_interval();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2000);
      2: return $urandom_range(200000, 100000);
      default: return $urandom_range(40000000);
    endcase
  endfunction

  task automatic random_records(int n);
    logic [191:0] d;
    logic [31:0] ra, da, tofv;
    repeat (n) begin
      case ($urandom_range(9))
        0: d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        1: d = from_intervals($urandom, $urandom, $urandom, $urandom);
        default: begin
          // plausible exchange: reply delays plus a short flight
          tofv = $urandom_range(3000);
          ra = rnd_interval();
          da = rnd_interval();
          d = from_intervals(ra + 2*tofv, da + 2*tofv + $urandom_range(50), da,
                             ra + $urandom_range(50));
        end
      endcase
      send_record(d);
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: divisor zero, extremes, saturation both ways
    send_record('0);
    send_record({6{32'hFFFF_FFFF}});
    send_record(from_intervals(0, 0, 0, 0));
    send_record(from_intervals(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    send_record(from_intervals(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_record(from_intervals(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_record(from_intervals(1, 0, 0, 0));
    send_record(from_intervals(0, 0, 1, 1));
    send_record(from_intervals(1000, 1000, 0, 0));
    send_record(from_intervals(100000, 100040, 100000, 100000));
    send_record(from_intervals(100040, 100000, 100000, 100000));
    send_record(from_intervals(100000, 100000, 100000, 100040));
    send_record({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h5555_5555});
    send_record({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hAAAA_AAAA});
    drain();
    write_scale(24'hFF_FFFF);
    send_record(from_intervals(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    send_record(from_intervals(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_record(from_intervals(200000, 200000, 1000, 1000));
    random_records(200);
    drain();
    write_scale(0);
    send_record(from_intervals(1000, 1000, 0, 0));
    random_records(150);
    drain();
    write_scale(dstof_pkg::SCALE_RESET);
    send_idle_pct = 45;
    random_records(200);
    drain();
    write_scale(24'($urandom_range(24'hFF_FFFF)));
    send_idle_pct = 0;
    recv_stall_pct = 45;
    random_records(200);
    drain();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    random_records(200);
    drain();
    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      random_records(100);
      begin
        hold_off = 1;
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();
    if (sb.errors == 0 && sb.flight_q.size() == 0) begin
      $display("PASS ds_twr_time_of_flight");
    end else begin
      $display("FAIL ds_twr_time_of_flight");
    end
    $finish;
  end
endmodule
